@@ src/safs_pkg.sv @@
package safs_pkg;

   // Table geometry
   localparam int SLOT_COUNT = 1024;
   localparam int SLOT_W     = 16;
   localparam int HANDLE_W   = 48;
   localparam int CMD_W      = 3;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int TOP_W      = $clog2(SLOT_COUNT + 1);

   typedef logic [SLOT_W:0] slot_ext_type;

   localparam slot_ext_type     SLOT_LIMIT = slot_ext_type'(SLOT_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
   localparam logic [TOP_W-1:0] TOP_FULL   = TOP_W'(SLOT_COUNT);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REINIT  = 3'd4;

   // Handle table port request
   typedef struct packed {
      logic                we;
      logic [IDX_W-1:0]    waddr;
      logic [HANDLE_W-1:0] wdata;
      logic [IDX_W-1:0]    raddr;
   } tbl_port_type;

   // Free stack port request
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [IDX_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } stk_port_type;

endpackage

@@ src/slot_allocator_free_stack_top.sv @@
// Slot allocator with a free-slot stack.
// Request channel (req_valid/req_ready) carries cmd, slot and handle; the
// response channel (rsp_valid/rsp_ready) returns result_slot, result_handle
// and ok, exactly one response per request, in order.
// Commands: allocate, lookup, set, release, reinitialize.
// One request is worked at a time; req_ready is high only when the
// sequencer is idle. Set and rejected requests answer directly; lookup and
// release make one table read; allocate pops stack entries until one names
// an empty slot; reinitialize runs a clearing pass.
// The sequencer returns to idle, and so can take the next request, in the
// same cycle that the response turns valid.
// The handle table and the stack memory each have a single read port:
// each pop reads the stack, then checks the table entry.
// After reset a clearing pass over all SLOT_COUNT slots empties the table
// and refills the stack; no request is taken during it.
// Results sit in an output register: if the receiver stalls, the block
// still takes the next request and holds its result until the slot frees.
module slot_allocator_free_stack_top
   import safs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [HANDLE_W-1:0] req_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_result_slot,
   output logic [HANDLE_W-1:0] rsp_result_handle,
   output logic                rsp_ok
);

   tbl_port_type        tbl_port;
   stk_port_type        stk_port;
   logic [HANDLE_W-1:0] tbl_rdata;
   logic [IDX_W-1:0]    stk_rdata;

   // Sequencer and result path
   safs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_handle        (req_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_result_handle (rsp_result_handle),
      .rsp_ok            (rsp_ok),
      .tbl_port          (tbl_port),
      .tbl_rdata         (tbl_rdata),
      .stk_port          (stk_port),
      .stk_rdata         (stk_rdata)
   );

   // Handle table
   safs_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (SLOT_COUNT)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_port.we),
      .wr_addr (tbl_port.waddr),
      .wr_data (tbl_port.wdata),
      .rd_addr (tbl_port.raddr),
      .rd_data (tbl_rdata)
   );

   // Free slot stack
   safs_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOT_COUNT)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_port.we),
      .wr_addr (stk_port.waddr),
      .wr_data (stk_port.wdata),
      .rd_addr (stk_port.raddr),
      .rd_data (stk_rdata)
   );

endmodule

@@ src/safs_ram.sv @@
module safs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/safs_ctrl.sv @@
module safs_ctrl
   import safs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [HANDLE_W-1:0] req_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_result_slot,
   output logic [HANDLE_W-1:0] rsp_result_handle,
   output logic                rsp_ok,
   output tbl_port_type        tbl_port,
   input  logic [HANDLE_W-1:0] tbl_rdata,
   output stk_port_type        stk_port,
   input  logic [IDX_W-1:0]    stk_rdata
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_POP   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [IDX_W-1:0]    cand_ff, cand_in;
   logic                from_req_ff, from_req_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                res_ok_ff, res_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic             req_in_range;
   logic             rd_empty;
   logic             rsp_free;
   logic [TOP_W-1:0] top_dec;

   // Shared zero compare on the table read port
   assign rd_empty     = (tbl_rdata == '0);
   assign req_in_range = slot_ext_type'(req_slot) < SLOT_LIMIT;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign top_dec      = top_ff - TOP_W'(1);
   assign req_ready    = (state_ff == ST_IDLE);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      handle_in     = handle_ff;
      top_in        = top_ff;
      clr_idx_in    = clr_idx_ff;
      cand_in       = cand_ff;
      from_req_in   = from_req_ff;
      res_slot_in   = res_slot_ff;
      res_handle_in = res_handle_ff;
      res_ok_in     = res_ok_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      tbl_port       = '0;
      tbl_port.raddr = slot_ff[IDX_W-1:0];
      stk_port       = '0;
      stk_port.raddr = top_dec[IDX_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            // Empty one slot and restore one stack entry per cycle
            tbl_port.we    = 1'b1;
            tbl_port.waddr = clr_idx_ff;
            tbl_port.wdata = '0;
            stk_port.we    = 1'b1;
            stk_port.waddr = clr_idx_ff;
            stk_port.wdata = LAST_IDX - clr_idx_ff;
            if (clr_idx_ff == LAST_IDX) begin
               top_in     = TOP_FULL;
               clr_idx_in = '0;
               if (from_req_ff) begin
                  from_req_in   = 1'b0;
                  res_slot_in   = slot_ff;
                  res_handle_in = '0;
                  res_ok_in     = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_idx_in = clr_idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               slot_in       = req_slot;
               handle_in     = req_handle;
               res_slot_in   = req_slot;
               res_handle_in = '0;
               res_ok_in     = 1'b0;
               state_in      = ST_DONE;
               unique case (req_cmd)
                  CMD_ALLOC: begin
                     res_slot_in = '0;
                     if (top_ff != '0) begin
                        top_in   = top_dec;
                        state_in = ST_POP;
                     end
                  end
                  CMD_LOOKUP: begin
                     tbl_port.raddr = req_slot[IDX_W-1:0];
                     if (req_in_range) begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_RELEASE: begin
                     tbl_port.raddr = req_slot[IDX_W-1:0];
                     if (req_in_range && req_slot != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_SET: begin
                     if (req_in_range) begin
                        tbl_port.we    = 1'b1;
                        tbl_port.waddr = req_slot[IDX_W-1:0];
                        tbl_port.wdata = req_handle;
                        res_ok_in      = 1'b1;
                     end
                  end
                  CMD_REINIT: begin
                     from_req_in = 1'b1;
                     clr_idx_in  = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            // Popped slot arrives; fetch its handle
            cand_in        = stk_rdata;
            tbl_port.raddr = stk_rdata;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_empty) begin
               tbl_port.we    = 1'b1;
               tbl_port.waddr = cand_ff;
               tbl_port.wdata = handle_ff;
               res_slot_in    = SLOT_W'(cand_ff);
               res_ok_in      = 1'b1;
               state_in       = ST_DONE;
            end else if (top_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               // Drop the stale entry and pop the next one
               top_in   = top_dec;
               state_in = ST_POP;
            end
         end
         ST_READ: begin
            res_ok_in = 1'b1;
            if (cmd_ff == CMD_LOOKUP) begin
               res_handle_in = tbl_rdata;
            end else if (!rd_empty) begin
               tbl_port.we    = 1'b1;
               tbl_port.waddr = slot_ff[IDX_W-1:0];
               tbl_port.wdata = '0;
               if (top_ff < TOP_FULL) begin
                  stk_port.we    = 1'b1;
                  stk_port.waddr = top_ff[IDX_W-1:0];
                  stk_port.wdata = slot_ff[IDX_W-1:0];
                  top_in         = top_ff + TOP_W'(1);
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the item to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_handle_in = res_handle_ff;
               rsp_ok_in     = res_ok_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         top_ff       <= TOP_FULL;
         clr_idx_ff   <= '0;
         from_req_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         clr_idx_ff   <= clr_idx_in;
         from_req_ff  <= from_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      handle_ff     <= handle_in;
      cand_ff       <= cand_in;
      res_slot_ff   <= res_slot_in;
      res_handle_ff <= res_handle_in;
      res_ok_ff     <= res_ok_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_slot   = rsp_slot_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_ok            = rsp_ok_ff;

   // Stack depth never exceeds the slot count
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_FULL)
      else $error("free stack depth overflow");

   // Every pop lowers the stack depth by exactly one
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> ($past(top_ff) == top_ff + TOP_W'(1)))
      else $error("pop without stack decrement");

   // A finished item waits while the output register is held
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_DONE))
      else $error("result overwrote a held item");

   // A completed clearing pass leaves the stack full
   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_idx_ff == LAST_IDX) |=> (top_ff == TOP_FULL))
      else $error("clearing pass did not refill the stack");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb
   import safs_pkg::*;
();

   // Command codes the block does not define
   localparam logic [CMD_W-1:0]    CMD_SPARE_LO    = 3'd5;
   localparam logic [CMD_W-1:0]    CMD_SPARE_HI    = 3'd7;
   localparam logic [HANDLE_W-1:0] HANDLE_ALL_ONES = '1;
   localparam logic [SLOT_W-1:0]   SLOT_ALL_ONES   = '1;

   typedef struct {
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] handle;
      logic                ok;
   } slot_result_type;

   // Mirror of the slot table and free stack, plus the results still owed
   class slot_alloc_tracker;
      logic [HANDLE_W-1:0] handles [SLOT_COUNT];
      logic [IDX_W-1:0]    free_slots [SLOT_COUNT];
      int unsigned         free_count;
      int unsigned         high_mark;
      slot_result_type     owed_results [$];
      int unsigned         errors;

      function new();
         errors    = 0;
         high_mark = 0;
         clear_table();
      endfunction

      // Empty every slot and refill the stack so slot 0 sits on top
      function void clear_table();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            handles[i]    = '0;
            free_slots[i] = IDX_W'(SLOT_COUNT - 1 - i);
         end
         free_count = SLOT_COUNT;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      task report(string msg);
         $display("tb: mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Apply one accepted request and queue the result it owes
      function void note_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                 logic [HANDLE_W-1:0] hnd);
         slot_result_type  res;
         logic [IDX_W-1:0] idx;
         logic             in_range;
         logic             found;
         res.slot   = slot;
         res.handle = '0;
         res.ok     = 1'b0;
         in_range   = (slot < SLOT_COUNT);
         idx        = slot[IDX_W-1:0];
         found      = 1'b0;
         case (cmd)
            CMD_ALLOC: begin
               res.slot = '0;
               // Pop until an empty slot turns up; drop stale entries
               while (free_count > 0 && !found) begin
                  free_count--;
                  idx = free_slots[free_count];
                  if (handles[idx] == '0) begin
                     handles[idx] = hnd;
                     res.slot     = SLOT_W'(idx);
                     res.ok       = 1'b1;
                     found        = 1'b1;
                     if (idx > high_mark) high_mark = idx;
                  end
               end
            end
            CMD_LOOKUP: begin
               if (in_range) begin
                  res.handle = handles[idx];
                  res.ok     = 1'b1;
               end
            end
            CMD_SET: begin
               if (in_range) begin
                  handles[idx] = hnd;
                  res.ok       = 1'b1;
               end
            end
            CMD_RELEASE: begin
               // Slot 0 is never handed back
               if (in_range && slot != '0) begin
                  res.ok = 1'b1;
                  if (handles[idx] != '0) begin
                     handles[idx] = '0;
                     if (free_count < SLOT_COUNT) begin
                        free_slots[free_count] = idx;
                        free_count++;
                     end
                  end
               end
            end
            CMD_REINIT: begin
               clear_table();
               res.ok = 1'b1;
            end
            default: begin
            end
         endcase
         owed_results.push_back(res);
      endfunction

      // Compare one delivered result against the oldest one owed
      task check_response(logic [SLOT_W-1:0] slot, logic [HANDLE_W-1:0] hnd, logic ok);
         slot_result_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("result with none owed: slot %0h handle %0h ok %0b",
                             slot, hnd, ok));
         end else begin
            want = owed_results.pop_front();
            if (slot !== want.slot)
               report($sformatf("result_slot got %0h want %0h", slot, want.slot));
            if (hnd !== want.handle)
               report($sformatf("result_handle got %0h want %0h", hnd, want.handle));
            if (ok !== want.ok)
               report($sformatf("ok got %0b want %0b", ok, want.ok));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [SLOT_W-1:0]   req_slot;
   logic [HANDLE_W-1:0] req_handle;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [SLOT_W-1:0]   rsp_result_slot;
   logic [HANDLE_W-1:0] rsp_result_handle;
   logic                rsp_ok;

   slot_alloc_tracker tracker;
   int unsigned       send_idle;
   int unsigned       recv_idle;
   int unsigned       recv_hold;

   slot_allocator_free_stack_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_handle        (req_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_result_handle (rsp_result_handle),
      .rsp_ok            (rsp_ok)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop for a hung run
   initial begin
      #(10_000_000);
      $display("tb: done, errors");
      $finish;
   end

   // Watch both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_result_slot, rsp_result_handle, rsp_ok);
         if (req_valid && req_ready)
            tracker.note_request(req_cmd, req_slot, req_handle);
      end
   end

   // Receiver: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (recv_hold - 1) @(negedge clock);
            recv_hold = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Offer one item, idling first at random, and hold it until taken
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                            logic [HANDLE_W-1:0] hnd);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_slot   <= slot;
      req_handle <= hnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drop_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic [HANDLE_W-1:0] pick_handle();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 8) return HANDLE_ALL_ONES;
      return HANDLE_W'({$urandom(), $urandom()});
   endfunction

   // Favor the dense low end where allocations land
   function automatic logic [SLOT_W-1:0] pick_slot();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 65) return SLOT_W'($urandom_range(0, tracker.high_mark));
      if (r < 80) return SLOT_W'($urandom_range(SLOT_COUNT - 1));
      if (r < 85) return '0;
      if (r < 88) return SLOT_W'(SLOT_COUNT - 1);
      if (r < 90) return SLOT_W'(SLOT_COUNT);
      return SLOT_W'($urandom_range(SLOT_ALL_ONES));
   endfunction

   // Drain mode fills the table through set and allocate to empty the stack
   task automatic random_item(bit drain);
      int unsigned         r;
      logic [CMD_W-1:0]    cmd;
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] hnd;
      r    = $urandom_range(99);
      slot = pick_slot();
      hnd  = pick_handle();
      if (drain) begin
         if (r < 90) begin
            cmd = CMD_ALLOC;
         end else if (r < 98) begin
            cmd  = CMD_SET;
            slot = SLOT_W'($urandom_range(SLOT_COUNT - 1));
         end else begin
            cmd = CMD_LOOKUP;
         end
      end else if (r < 33) begin
         cmd = CMD_ALLOC;
      end else if (r < 53) begin
         cmd = CMD_LOOKUP;
      end else if (r < 68) begin
         cmd = CMD_SET;
      end else if (r < 87) begin
         cmd = CMD_RELEASE;
      end else if (r < 88) begin
         cmd = CMD_REINIT;
      end else if (r < 96) begin
         cmd = CMD_LOOKUP;
      end else begin
         cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      send_item(cmd, slot, hnd);
   endtask

   initial begin
      int unsigned n;
      int unsigned wait_cycles;
      tracker    = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_cmd    = CMD_LOOKUP;
      req_slot   = '0;
      req_handle = '0;
      rsp_ready  = 1'b0;
      send_idle  = 22;
      recv_idle  = 73;
      recv_hold  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, stale pops, range checks, release corners
      send_item(CMD_LOOKUP, '0, '0);
      send_item(CMD_ALLOC, '0, HANDLE_ALL_ONES);
      send_item(CMD_LOOKUP, '0, '0);
      send_item(CMD_ALLOC, '0, '0);
      send_item(CMD_ALLOC, SLOT_ALL_ONES, HANDLE_W'(1));
      send_item(CMD_SET, SLOT_W'(3), HANDLE_W'(48'h5a5a_0000_a5a5));
      send_item(CMD_ALLOC, '0, HANDLE_W'(48'h8000_0000_0001));
      send_item(CMD_SET, SLOT_W'(SLOT_COUNT - 1), HANDLE_W'(48'h7fff_ffff_fffe));
      send_item(CMD_LOOKUP, SLOT_W'(SLOT_COUNT - 1), '0);
      send_item(CMD_SET, SLOT_W'(SLOT_COUNT), HANDLE_ALL_ONES);
      send_item(CMD_LOOKUP, SLOT_ALL_ONES, HANDLE_ALL_ONES);
      send_item(CMD_RELEASE, SLOT_ALL_ONES, '0);
      send_item(CMD_RELEASE, '0, '0);
      send_item(CMD_RELEASE, SLOT_W'(1), '0);
      send_item(CMD_RELEASE, SLOT_W'(4), '0);
      send_item(CMD_ALLOC, '0, HANDLE_W'(48'h0123_4567_89ab));
      send_item(CMD_SPARE_LO, SLOT_W'(2), HANDLE_ALL_ONES);
      send_item(CMD_W'(CMD_SPARE_LO + 1), SLOT_ALL_ONES, '0);
      send_item(CMD_SPARE_HI, SLOT_W'(SLOT_COUNT), HANDLE_W'(7));
      send_item(CMD_REINIT, SLOT_ALL_ONES, HANDLE_ALL_ONES);
      // Release with the stack full: emptied, not pushed
      send_item(CMD_SET, SLOT_W'(9), HANDLE_W'(48'hdead_beef_0009));
      send_item(CMD_RELEASE, SLOT_W'(9), '0);
      send_item(CMD_LOOKUP, SLOT_W'(9), '0);
      send_item(CMD_ALLOC, '0, HANDLE_W'(48'hcafe_0000_0000));

      // Pause until every owed result is back
      drop_req();
      while (tracker.pending() != 0) @(negedge clock);

      // Phase one: sender idles lightly, receiver heavily
      for (n = 0; n < 60; n++) random_item(1'b0);

      // Phase two: roles swapped, opening with a long receiver hold-off
      send_idle = 73;
      recv_idle = 22;
      recv_hold = 400;
      for (n = 0; n < 60; n++) random_item(1'b0);

      // Phase three: no idling; run the stack dry, then keep mixing
      send_idle = 0;
      recv_idle = 0;
      n = 0;
      while (tracker.free_count > 0 && n < 1100) begin
         random_item(1'b1);
         n++;
      end
      for (n = 0; n < 20; n++) random_item(1'b0);

      // Drain the results still owed, then let the block settle
      drop_req();
      wait_cycles = 0;
      while (tracker.pending() != 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d results never arrived", tracker.pending()));
      if (tracker.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
